/* hdl/refcounted_buffer_pool_assert.svh */
// ---------------------------------------------------------------------------
// Refcounted buffer pool assertion macros
// Clocked property checks used by the pool top level.
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_BUFFER_POOL_ASSERT_SVH
`define REFCOUNTED_BUFFER_POOL_ASSERT_SVH

// check a property on every clock edge outside reset
`define RCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that an expression never holds outside reset
`define RCBP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* hdl/rcbp_pkg.sv */
// ---------------------------------------------------------------------------
// Refcounted buffer pool package
// Sizes, action and status codes and the request and response structs.
// ---------------------------------------------------------------------------
`default_nettype none

package rcbp_pkg;

  localparam int POOL_ENTRIES = 8;
  localparam int REF_BITS     = 8;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int TOP_W        = $clog2(POOL_ENTRIES + 1);
  localparam int COUNT_OUT_W  = 8;
  localparam int FREE_OUT_W   = 4;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 24;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ADDREF  = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_UNREF  = 2'd2,
    ST_BADREF = 2'd3
  } status_e;

  typedef struct packed {
    action_e          action;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic                   granted;
    logic [IDX_W-1:0]       granted_index;
    status_e                status;
    logic [COUNT_OUT_W-1:0] ref_count;
    logic [FREE_OUT_W-1:0]  free_count;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/rcbp_core.sv */
// ---------------------------------------------------------------------------
// Refcounted buffer pool core
// Free stack, free top and reference counts, updated once per request.
// ---------------------------------------------------------------------------
`default_nettype none

module rcbp_core
  import rcbp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  input  req_t      req_i,
  output rsp_t      rsp_o
);

  localparam logic [REF_BITS-1:0] CountMax = '1;

  logic [IDX_W-1:0]    stack_q [POOL_ENTRIES];
  logic [REF_BITS-1:0] cnt_q   [POOL_ENTRIES];
  logic [TOP_W-1:0]    top_q, top_d;

  logic [TOP_W-1:0]    top_m1;
  logic [IDX_W-1:0]    pop_idx;
  logic [REF_BITS-1:0] cur_cnt;
  logic                in_pool;

  logic                cnt_we;
  logic [IDX_W-1:0]    cnt_waddr;
  logic [REF_BITS-1:0] cnt_wdata;
  logic                push;

  assign top_m1  = top_q - TOP_W'(1);
  assign pop_idx = stack_q[top_m1[IDX_W-1:0]];
  assign cur_cnt = cnt_q[req_i.idx];
  assign in_pool = TOP_W'(req_i.idx) < TOP_W'(POOL_ENTRIES);

  always_comb begin
    top_d                = top_q;
    cnt_we               = 1'b0;
    cnt_waddr            = req_i.idx;
    cnt_wdata            = cur_cnt;
    push                 = 1'b0;
    rsp_o.granted        = 1'b0;
    rsp_o.granted_index  = req_i.idx;
    rsp_o.status         = ST_OK;
    rsp_o.ref_count      = COUNT_OUT_W'(cur_cnt);
    case (req_i.action)
      ACT_ALLOC: begin
        if (top_q == '0) begin
          rsp_o.status        = ST_EMPTY;
          rsp_o.granted_index = '0;
          rsp_o.ref_count     = '0;
        end else begin
          top_d               = top_m1;
          cnt_we              = 1'b1;
          cnt_waddr           = pop_idx;
          cnt_wdata           = REF_BITS'(1);
          rsp_o.granted       = 1'b1;
          rsp_o.granted_index = pop_idx;
          rsp_o.ref_count     = COUNT_OUT_W'(1);
        end
      end
      ACT_RELEASE: begin
        if (!in_pool) begin
          rsp_o.status    = ST_BADREF;
          rsp_o.ref_count = '0;
        end else if (cur_cnt == '0) begin
          rsp_o.status    = ST_UNREF;
          rsp_o.ref_count = '0;
        end else begin
          cnt_we          = 1'b1;
          cnt_wdata       = cur_cnt - REF_BITS'(1);
          rsp_o.ref_count = COUNT_OUT_W'(cnt_wdata);
          if (cnt_wdata == '0 && top_q < TOP_W'(POOL_ENTRIES)) begin
            push  = 1'b1;
            top_d = top_q + TOP_W'(1);
          end
        end
      end
      ACT_ADDREF: begin
        if (!in_pool) begin
          rsp_o.status    = ST_BADREF;
          rsp_o.ref_count = '0;
        end else if (cur_cnt == '0 || cur_cnt == CountMax) begin
          rsp_o.status    = ST_BADREF;
        end else begin
          cnt_we          = 1'b1;
          cnt_wdata       = cur_cnt + REF_BITS'(1);
          rsp_o.ref_count = COUNT_OUT_W'(cnt_wdata);
        end
      end
      default: begin
        if (!in_pool) begin
          rsp_o.ref_count = '0;
        end
      end
    endcase
    rsp_o.free_count = FREE_OUT_W'(top_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TOP_W'(POOL_ENTRIES);
      for (int k = 0; k < POOL_ENTRIES; k++) begin
        stack_q[k] <= IDX_W'(k);
        cnt_q[k]   <= '0;
      end
    end else if (req_valid_i) begin
      top_q <= top_d;
      if (cnt_we) begin
        cnt_q[cnt_waddr] <= cnt_wdata;
      end
      if (push) begin
        stack_q[top_q[IDX_W-1:0]] <= req_i.idx;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/refcounted_buffer_pool.sv */
// ---------------------------------------------------------------------------
// Refcounted buffer pool
// LIFO free list of buffer entries with a reference count per entry.
// ---------------------------------------------------------------------------
//  channel   dir   payload (tdata, low bit up)
//  s_*       in    action[1:0], entry_index[4:2]
//  m_*       out   granted[0], granted_index[3:1], status[5:4],
//                  ref_count[13:6], free_count[17:14]
//
//  One request per cycle sustained while the output is not stalled; the input
//  register feeds the core and the result register captures its reply.
//  The stack and count registers are updated together with the result register.
//  After reset all entries are free, counts are zero, highest index first.
//  A stalled result holds in the result register; the input register keeps
//  accepting until both stages are full.
// ---------------------------------------------------------------------------
`default_nettype none

module refcounted_buffer_pool
  import rcbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,   // action, entry_index
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0]      m_tdata_o    // granted, granted_index, status,
                                                  // ref_count, free_count
);

  logic in_valid_q;
  req_t in_req_q;
  logic out_valid_q;
  rsp_t out_rsp_q;
  rsp_t core_rsp;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_req_q.action <= action_e'(s_tdata_i[1:0]);
      in_req_q.idx    <= s_tdata_i[2 +: IDX_W];
    end
    if (advance) begin
      out_rsp_q <= core_rsp;
    end
  end

  rcbp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (advance),
    .req_i       (in_req_q),
    .rsp_o       (core_rsp)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'd0, out_rsp_q.free_count, out_rsp_q.ref_count,
                       out_rsp_q.status, out_rsp_q.granted_index, out_rsp_q.granted};

`include "refcounted_buffer_pool_assert.svh"

  `RCBP_ASSERT(a_free_bound,
    m_tvalid_o |-> (out_rsp_q.free_count <= FREE_OUT_W'(POOL_ENTRIES)),
    "free count above pool size")
  `RCBP_ASSERT(a_grant_ok,
    (m_tvalid_o && out_rsp_q.granted) |->
      (out_rsp_q.status == ST_OK && out_rsp_q.ref_count == COUNT_OUT_W'(1)),
    "grant without ok status and count one")
  `RCBP_ASSERT(a_empty_zero,
    (m_tvalid_o && out_rsp_q.status == ST_EMPTY) |->
      (out_rsp_q.free_count == '0 && !out_rsp_q.granted),
    "empty status with free entries")
  `RCBP_ASSERT_NEVER(a_full_ready,
    in_valid_q && out_valid_q && !m_tready_i && s_tready_o,
    "ready while both stages are stalled")

endmodule

`default_nettype wire

/* test/rcbp_pool_checker.sv */
// ---------------------------------------------------------------------------
// Buffer pool response checker
// Watches both stream channels of the pool. Each request taken on the input
// channel runs through a behavioral copy of the free stack and reference
// counts. The predicted reply is queued, and each reply taken on the output
// channel is compared field by field with the oldest queued one. Reports the
// error count and the number of replies still outstanding.
// ---------------------------------------------------------------------------
module rcbp_pool_checker
  import rcbp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // action, entry_index
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,   // granted, granted_index, status,
                                             // ref_count, free_count
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REF_BITS-1:0] COUNT_SAT = '1;

  logic [IDX_W-1:0]    free_stack [POOL_ENTRIES];
  logic [TOP_W-1:0]    free_top;
  logic [REF_BITS-1:0] ref_counts [POOL_ENTRIES];
  rsp_t                pool_replies_q [$];

  function automatic rsp_t pool_update(input action_e act, input logic [IDX_W-1:0] idx);
    rsp_t             r;
    logic [IDX_W-1:0] e;
    r.granted       = 1'b0;
    r.granted_index = idx;
    r.status        = ST_OK;
    r.ref_count     = '0;
    case (act)
      ACT_ALLOC: begin
        if (free_top == 0) begin
          r.granted_index = '0;
          r.status        = ST_EMPTY;
        end else begin
          free_top        = free_top - 1'b1;
          e               = free_stack[free_top];
          ref_counts[e]   = 1;
          r.granted       = 1'b1;
          r.granted_index = e;
          r.ref_count     = 1;
        end
      end
      ACT_RELEASE: begin
        if (ref_counts[idx] == 0) begin
          r.status = ST_UNREF;
        end else begin
          ref_counts[idx] = ref_counts[idx] - 1'b1;
          if (ref_counts[idx] == 0 && free_top < POOL_ENTRIES) begin
            free_stack[free_top] = idx;
            free_top             = free_top + 1'b1;
          end
          r.ref_count = ref_counts[idx];
        end
      end
      ACT_ADDREF: begin
        if (ref_counts[idx] == 0 || ref_counts[idx] == COUNT_SAT) begin
          r.status = ST_BADREF;
        end else begin
          ref_counts[idx] = ref_counts[idx] + 1'b1;
        end
        r.ref_count = ref_counts[idx];
      end
      default: begin
        r.ref_count = ref_counts[idx];
      end
    endcase
    r.free_count = free_top;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      for (int k = 0; k < POOL_ENTRIES; k++) begin
        free_stack[k] = IDX_W'(k);
        ref_counts[k] = '0;
      end
      free_top = TOP_W'(POOL_ENTRIES);
      pool_replies_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pool_replies_q.push_back(pool_update(action_e'(s_tdata_i[1:0]), s_tdata_i[4:2]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pool_replies_q.size() == 0) begin
          $error("reply transaction 0x%06h with no request outstanding", m_tdata_i);
          errors_o++;
        end else begin
          exp_rsp = pool_replies_q.pop_front();
          check_field("granted", exp_rsp.granted, m_tdata_i[0]);
          check_field("granted_index", exp_rsp.granted_index, m_tdata_i[3:1]);
          check_field("status", exp_rsp.status, m_tdata_i[5:4]);
          check_field("ref_count", exp_rsp.ref_count, m_tdata_i[13:6]);
          check_field("free_count", exp_rsp.free_count, m_tdata_i[17:14]);
        end
      end
      pending_o = pool_replies_q.size();
    end
  end

endmodule

/* test/tb_refcounted_buffer_pool.sv */
// ---------------------------------------------------------------------------
// Refcounted buffer pool testbench
// Drives allocate, release, add-reference and unused-code requests into the
// pool with random gaps and output back-pressure: a directed opening, a walk
// of one entry up to a saturated count and back to free, then random traffic
// with pool-draining and release-sweep bursts. The checker predicts and
// compares every reply; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_refcounted_buffer_pool;
  import rcbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL     = 400;
  localparam int RANDOM_ROUNDS  = 275;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i;
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [OUT_DATA_W-1:0] m_tdata_o;

  int errors;
  int pending;
  int sent_by_action [4];
  int total_sent;
  int idle_cycles;
  bit sender_steady;
  bit stall_done;

  refcounted_buffer_pool dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  rcbp_pool_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_i (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_i (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_i  (m_tdata_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int idle_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input action_e act, input logic [IDX_W-1:0] idx);
    int gap;
    gap = idle_gap(sender_steady);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i  = {3'b000, idx, act};
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
    sent_by_action[act]++;
    total_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
               idle_cycles, pending);
      $display("tb_refcounted_buffer_pool: errors");
      $finish;
    end
  end

  initial begin
    int gap;
    m_tready_i = 1'b0;
    stall_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!stall_done && total_sent >= 120) begin
        m_tready_i = 1'b0;
        repeat (LONG_STALL) @(negedge clk_i);
        stall_done = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) begin
        m_tready_i = 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end
      gap = idle_gap(1'b0);
      if (gap > 0) begin
        m_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      @(negedge clk_i);
    end
  end

  initial begin
    int r;
    s_tvalid_i    = 1'b0;
    s_tdata_i     = '0;
    rst_ni        = 1'b0;
    idle_cycles   = 0;
    total_sent    = 0;
    sender_steady = 1'b0;
    sent_by_action = '{default: 0};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // opening: errors on an idle pool, drain it, empty, free and reuse
    send_request(ACT_RELEASE, 3'd3);
    send_request(ACT_ADDREF, 3'd2);
    send_request(ACT_NOP, 3'd6);
    repeat (POOL_ENTRIES) send_request(ACT_ALLOC, 3'd0);
    send_request(ACT_ALLOC, 3'd5);
    send_request(ACT_ADDREF, 3'd0);
    send_request(ACT_RELEASE, 3'd0);
    send_request(ACT_RELEASE, 3'd0);
    send_request(ACT_RELEASE, 3'd0);
    send_request(ACT_ALLOC, 3'd0);
    send_request(ACT_NOP, 3'd7);
    send_request(ACT_ADDREF, 3'd7);

    // drive entry 4 to a saturated count, then release it back to the pool
    sender_steady = 1'b1;
    repeat (256) send_request(ACT_ADDREF, 3'd4);
    sender_steady = 1'b0;
    repeat (255) send_request(ACT_RELEASE, 3'd4);
    wait_drained();

    for (int n = 0; n < RANDOM_ROUNDS; n++) begin
      if (n == RANDOM_ROUNDS / 2) wait_drained();
      if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        repeat (POOL_ENTRIES + 1) send_request(ACT_ALLOC, IDX_W'($urandom));
      end else if (r < 7) begin
        for (int k = 0; k < POOL_ENTRIES; k++) send_request(ACT_RELEASE, IDX_W'(k));
      end else if (r < 35) begin
        send_request(ACT_ALLOC, IDX_W'($urandom));
      end else if (r < 65) begin
        send_request(ACT_RELEASE, IDX_W'($urandom));
      end else if (r < 95) begin
        send_request(ACT_ADDREF, IDX_W'($urandom));
      end else begin
        send_request(ACT_NOP, IDX_W'($urandom));
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("covered %0d requests: %0d allocate, %0d release, %0d add-reference, %0d unused code",
             total_sent, sent_by_action[ACT_ALLOC], sent_by_action[ACT_RELEASE],
             sent_by_action[ACT_ADDREF], sent_by_action[ACT_NOP]);
    $display("count saturation, empty pool, a %0d-cycle output stall and drain pauses exercised",
             LONG_STALL);
    if (errors == 0) begin
      $display("tb_refcounted_buffer_pool: clean");
    end else begin
      $display("tb_refcounted_buffer_pool: errors");
    end
    $finish;
  end

endmodule
